// ===== hdl/mrc_pkg.sv =====
// Shared types, constants and helpers for the mixed radix index converter.
package mrc_pkg;

    // Field and stride widths fixed by the item format.
    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned STRIDE_W  = 31;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_OUTER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_THIRD  = 2'd2;

    // Operation codes.
    localparam logic OP_PACK   = 1'b0;
    localparam logic OP_UNPACK = 1'b1;

    // Pipeline depths: front end, three restoring dividers, output register.
    localparam int unsigned FRONT_STAGES = 3;
    localparam int unsigned DIV_STAGES   = FIELD_W;
    localparam int unsigned LATENCY      = FRONT_STAGES + 3 * DIV_STAGES + 1;

    // One input item.
    typedef struct packed {
        logic                      op;
        logic signed [FIELD_W-1:0] start_a;
        logic signed [FIELD_W-1:0] start_b;
        logic signed [FIELD_W-1:0] start_c;
        logic signed [FIELD_W-1:0] start_d;
        logic signed [FIELD_W-1:0] offset_a;
        logic signed [FIELD_W-1:0] offset_b;
        logic signed [FIELD_W-1:0] offset_c;
        logic signed [FIELD_W-1:0] offset_d;
        logic signed [FIELD_W-1:0] linear_index;
    } request_t;

    // One result item.
    typedef struct packed {
        logic signed [FIELD_W-1:0] packed_index;
        logic signed [FIELD_W-1:0] coord_a;
        logic signed [FIELD_W-1:0] coord_b;
        logic signed [FIELD_W-1:0] coord_c;
        logic signed [FIELD_W-1:0] coord_d;
    } result_t;

    // Sideband that rides along the divider chain with each item.
    typedef struct packed {
        logic               op;
        logic               neg;
        logic [FIELD_W-1:0] packed_index;
        logic [FIELD_W-1:0] quot_a;
        logic [FIELD_W-1:0] quot_b;
    } side_t;

    // Two's complement negation of a field-wide value.
    function automatic logic [FIELD_W-1:0] negate(input logic [FIELD_W-1:0] v);
        return ~v + {{(FIELD_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// ===== hdl/mixed_radix_index_converter_unit.sv =====
// Top level of the mixed radix index converter: strides, divider chain and result register.
//
// The unit takes one item in every clock cycle once out of reset (busy is high only
// during the first cycle after reset) and delivers its result with done high for a
// single cycle. The pipeline holds the three chained 32-stage restoring dividers of
// the unpack path, plus three front-end stages for the pack sums and products and one
// output register; pack items travel through the same pipeline so results leave in
// acceptance order. Results cannot be held off, so the receiver must take every result
// in the cycle that it appears. Stride registers are written through cfg_we, cfg_index
// and cfg_data and must only change while no item is in flight.
module mixed_radix_index_converter_unit #(
    parameter int unsigned INDEX_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mrc_pkg::request_t             request,
    output logic                          done,
    output mrc_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mrc_pkg::STRIDE_W-1:0]  cfg_data
);

    logic [mrc_pkg::STRIDE_W-1:0] stride_outer_reg;
    logic [mrc_pkg::STRIDE_W-1:0] stride_second_reg;
    logic [mrc_pkg::STRIDE_W-1:0] stride_third_reg;
    logic                         run_reg;
    logic                         done_reg;
    mrc_pkg::result_t             result_reg;
    mrc_pkg::result_t             result_next;

    logic                         accept;
    logic                         front_valid;
    mrc_pkg::side_t               front_side;
    logic [mrc_pkg::FIELD_W-1:0]  front_mag;

    logic                         va;
    logic                         vb;
    logic                         vc;
    logic [mrc_pkg::FIELD_W-1:0]  quot_a;
    logic [mrc_pkg::FIELD_W-1:0]  quot_b;
    logic [mrc_pkg::FIELD_W-1:0]  quot_c;
    logic [mrc_pkg::FIELD_W-1:0]  rem_a;
    logic [mrc_pkg::FIELD_W-1:0]  rem_b;
    logic [mrc_pkg::FIELD_W-1:0]  rem_c;
    mrc_pkg::side_t               side_a;
    mrc_pkg::side_t               side_b;
    mrc_pkg::side_t               side_c;
    mrc_pkg::side_t               side_b_in;
    mrc_pkg::side_t               side_c_in;

    assign busy   = ~run_reg;
    assign accept = start & ~busy;

    // Stride registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_outer_reg  <= mrc_pkg::STRIDE_W'(1);
            stride_second_reg <= mrc_pkg::STRIDE_W'(1);
            stride_third_reg  <= mrc_pkg::STRIDE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mrc_pkg::CFG_STRIDE_OUTER:  stride_outer_reg  <= cfg_data;
                mrc_pkg::CFG_STRIDE_SECOND: stride_second_reg <= cfg_data;
                mrc_pkg::CFG_STRIDE_THIRD:  stride_third_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Run flag and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= 1'b1;
            done_reg <= vc;
        end
    end

    // Pack arithmetic and index magnitude.
    mrc_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .in_item       (request),
        .stride_outer  (stride_outer_reg),
        .stride_second (stride_second_reg),
        .stride_third  (stride_third_reg),
        .out_valid     (front_valid),
        .out_side      (front_side),
        .out_mag       (front_mag)
    );

    // First division, by the outer stride.
    mrc_div u_div_a (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (front_valid),
        .in_dividend (front_mag),
        .in_side     (front_side),
        .divisor     (stride_outer_reg),
        .out_valid   (va),
        .out_quot    (quot_a),
        .out_rem     (rem_a),
        .out_side    (side_a)
    );

    // The first and second quotients join the sideband before the next division.
    always_comb
    begin
        side_b_in        = side_a;
        side_b_in.quot_a = quot_a;
        side_c_in        = side_b;
        side_c_in.quot_b = quot_b;
    end

    // Second division, by the second stride.
    mrc_div u_div_b (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (va),
        .in_dividend (rem_a),
        .in_side     (side_b_in),
        .divisor     (stride_second_reg),
        .out_valid   (vb),
        .out_quot    (quot_b),
        .out_rem     (rem_b),
        .out_side    (side_b)
    );

    // Third division, by the third stride.
    mrc_div u_div_c (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (vb),
        .in_dividend (rem_b),
        .in_side     (side_c_in),
        .divisor     (stride_third_reg),
        .out_valid   (vc),
        .out_quot    (quot_c),
        .out_rem     (rem_c),
        .out_side    (side_c)
    );

    // Restore signs and select the fields that the operation defines.
    always_comb
    begin
        result_next = '0;
        if (side_c.op == mrc_pkg::OP_PACK)
        begin
            result_next.packed_index = side_c.packed_index;
        end
        else if (side_c.neg)
        begin
            result_next.coord_a = mrc_pkg::negate(side_c.quot_a);
            result_next.coord_b = mrc_pkg::negate(side_c.quot_b);
            result_next.coord_c = mrc_pkg::negate(quot_c);
            result_next.coord_d = mrc_pkg::negate(rem_c);
        end
        else
        begin
            result_next.coord_a = side_c.quot_a;
            result_next.coord_b = side_c.quot_b;
            result_next.coord_c = quot_c;
            result_next.coord_d = rem_c;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every result follows an accepted item by the full pipeline depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, mrc_pkg::LATENCY))
        else $error("result without an accepted item");

    // An unpack remainder carries the sign of the index it came from.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(request.op, mrc_pkg::LATENCY) == mrc_pkg::OP_UNPACK) &&
        (result.coord_d != '0)
        |-> (result.coord_d[mrc_pkg::FIELD_W-1] ==
             $past(request.linear_index[mrc_pkg::FIELD_W-1], mrc_pkg::LATENCY)))
        else $error("unpack remainder sign mismatch");

endmodule

// ===== hdl/mrc_front.sv =====
// Front end: pack arithmetic in three stages and the magnitude of the unpack index.
module mrc_front #(
    parameter int unsigned INDEX_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  mrc_pkg::request_t                     in_item,
    input  logic [mrc_pkg::STRIDE_W-1:0]          stride_outer,
    input  logic [mrc_pkg::STRIDE_W-1:0]          stride_second,
    input  logic [mrc_pkg::STRIDE_W-1:0]          stride_third,
    output logic                                  out_valid,
    output mrc_pkg::side_t                        out_side,
    output logic [mrc_pkg::FIELD_W-1:0]           out_mag
);

    // Only the low bits of the wrapped sum reach the 32-bit result.
    localparam int unsigned PACK_W = (INDEX_WIDTH < mrc_pkg::FIELD_W) ?
                                     INDEX_WIDTH : mrc_pkg::FIELD_W;
    localparam int unsigned MUL_W  = PACK_W + mrc_pkg::STRIDE_W;

    logic [2:0] vld_reg;

    // Stage 1 registers.
    logic                        op1_reg;
    logic                        neg1_reg;
    logic [mrc_pkg::FIELD_W-1:0] mag1_reg;
    logic [PACK_W-1:0]           sum_a_reg;
    logic [PACK_W-1:0]           sum_b_reg;
    logic [PACK_W-1:0]           sum_c_reg;
    logic [PACK_W-1:0]           sum_d_reg;

    // Stage 2 registers.
    logic                        op2_reg;
    logic                        neg2_reg;
    logic [mrc_pkg::FIELD_W-1:0] mag2_reg;
    logic [PACK_W-1:0]           prod_a_reg;
    logic [PACK_W-1:0]           prod_b_reg;
    logic [PACK_W-1:0]           prod_c_reg;
    logic [PACK_W-1:0]           term_d_reg;

    // Stage 3 registers.
    mrc_pkg::side_t              side3_reg;
    logic [mrc_pkg::FIELD_W-1:0] mag3_reg;

    // Stage 1 logic.
    logic [mrc_pkg::FIELD_W-1:0] sum_full_a;
    logic [mrc_pkg::FIELD_W-1:0] sum_full_b;
    logic [mrc_pkg::FIELD_W-1:0] sum_full_c;
    logic [mrc_pkg::FIELD_W-1:0] sum_full_d;
    logic                        neg1_next;
    logic [mrc_pkg::FIELD_W-1:0] mag1_next;

    // Stage 2 logic.
    logic [MUL_W-1:0]            mul_a;
    logic [MUL_W-1:0]            mul_b;
    logic [MUL_W-1:0]            mul_c;

    // Stage 3 logic.
    logic [PACK_W-1:0]           total;
    mrc_pkg::side_t              side3_next;

    // Element-wise sums and the sign and magnitude of the index.
    always_comb
    begin
        sum_full_a = in_item.start_a + in_item.offset_a;
        sum_full_b = in_item.start_b + in_item.offset_b;
        sum_full_c = in_item.start_c + in_item.offset_c;
        sum_full_d = in_item.start_d + in_item.offset_d;
        neg1_next  = in_item.linear_index[mrc_pkg::FIELD_W-1];
        mag1_next  = neg1_next ? mrc_pkg::negate(in_item.linear_index) :
                                 in_item.linear_index;
    end

    // One product per strided coordinate.
    always_comb
    begin
        mul_a = sum_a_reg * stride_outer;
        mul_b = sum_b_reg * stride_second;
        mul_c = sum_c_reg * stride_third;
    end

    // Final sum, zero-extended to the field width.
    always_comb
    begin
        total                               = prod_a_reg + prod_b_reg + prod_c_reg + term_d_reg;
        side3_next                          = '0;
        side3_next.op                       = op2_reg;
        side3_next.neg                      = neg2_reg;
        side3_next.packed_index[PACK_W-1:0] = total;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        op1_reg    <= in_item.op;
        neg1_reg   <= neg1_next;
        mag1_reg   <= mag1_next;
        sum_a_reg  <= sum_full_a[PACK_W-1:0];
        sum_b_reg  <= sum_full_b[PACK_W-1:0];
        sum_c_reg  <= sum_full_c[PACK_W-1:0];
        sum_d_reg  <= sum_full_d[PACK_W-1:0];

        op2_reg    <= op1_reg;
        neg2_reg   <= neg1_reg;
        mag2_reg   <= mag1_reg;
        prod_a_reg <= mul_a[PACK_W-1:0];
        prod_b_reg <= mul_b[PACK_W-1:0];
        prod_c_reg <= mul_c[PACK_W-1:0];
        term_d_reg <= sum_d_reg;

        side3_reg  <= side3_next;
        mag3_reg   <= mag2_reg;
    end

    assign out_valid = vld_reg[2];
    assign out_side  = side3_reg;
    assign out_mag   = mag3_reg;

endmodule

// ===== hdl/mrc_div.sv =====
// Pipelined restoring divider of a magnitude by a stride, one quotient bit per stage.
module mrc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [mrc_pkg::FIELD_W-1:0]  in_dividend,
    input  mrc_pkg::side_t               in_side,
    input  logic [mrc_pkg::STRIDE_W-1:0] divisor,
    output logic                         out_valid,
    output logic [mrc_pkg::FIELD_W-1:0]  out_quot,
    output logic [mrc_pkg::FIELD_W-1:0]  out_rem,
    output mrc_pkg::side_t               out_side
);

    localparam int unsigned DW  = mrc_pkg::FIELD_W;
    localparam int unsigned DWP = DW + 1;
    localparam int unsigned NS  = mrc_pkg::DIV_STAGES;

    logic [NS-1:0]  vld_reg;
    logic [DW-1:0]  rem_reg  [NS];
    logic [DW-1:0]  quo_reg  [NS];
    mrc_pkg::side_t side_reg [NS];

    logic [DW-1:0]  rem_next [NS];
    logic [DW-1:0]  quo_next [NS];
    logic [DW-1:0]  src_rem;
    logic [DW-1:0]  src_quo;
    logic [DWP-1:0] trial;
    logic [DWP-1:0] diff;
    logic [DWP-1:0] ext_div;
    logic           ge;

    // Each stage shifts in the next dividend bit and tries one subtraction.
    always_comb
    begin
        ext_div = DWP'(divisor);
        src_rem = '0;
        src_quo = '0;
        trial   = '0;
        diff    = '0;
        ge      = 1'b0;
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                src_rem = '0;
                src_quo = in_dividend;
            end
            else
            begin
                src_rem = rem_reg[s-1];
                src_quo = quo_reg[s-1];
            end
            trial       = {src_rem, src_quo[DW-1]};
            diff        = trial - ext_div;
            ge          = (trial >= ext_div);
            rem_next[s] = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next[s] = {src_quo[DW-2:0], ge};
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS; s++)
        begin
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
            if (s == 0)
            begin
                side_reg[s] <= in_side;
            end
            else
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // A zero stride yields quotient zero; the remainder is then the dividend.
    assign out_valid = vld_reg[NS-1];
    assign out_quot  = (divisor == '0) ? '0 : quo_reg[NS-1];
    assign out_rem   = rem_reg[NS-1];
    assign out_side  = side_reg[NS-1];

    // The remainder always ends below a nonzero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (divisor != '0) |-> (out_rem < DW'(divisor)))
        else $error("divider remainder not below divisor");

    // An item leaves exactly one divider depth after it entered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, NS))
        else $error("divider output without matching input");

endmodule
